>>> hdl/fbc_pkg.sv
// Shared definitions for the foreground bounding-box crop core.
// Register indexes, fixed field widths, reset values and the stage control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

	localparam int DEF_COORD_BITS = 12;
	localparam int DEF_PIXEL_BITS = 16;

	// Q8.8 margin factor
	localparam int MARGIN_BITS = 16;
	localparam int MARGIN_FRAC = 8;
	localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd256;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BACKGROUND = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_X      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_Y      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_Z      = 3'd4;

	// Write data is as wide as the widest register.
	function automatic int cfg_w(input int pixel_bits, input int coord_bits);
		int w;
		w = MARGIN_BITS;
		if (pixel_bits > w) w = pixel_bits;
		if (coord_bits + 1 > w) w = coord_bits + 1;
		return w;
	endfunction

	// Controls from the pipeline sequencer to the accumulator
	typedef struct packed {
		logic load_s1;  // take a voxel into the input register
		logic step_s1;  // fold the input register into the running box, or clear it after a last voxel
		logic load_s2;  // hand the finished box on
	} acc_ctl_t;

endpackage

`default_nettype wire

>>> hdl/foreground_bounding_box_crop_core.sv
// Top level of the foreground bounding-box crop core: stage sequencing and wiring.
// Depends on fbc_pkg, fbc_cfg, fbc_accum and fbc_axis.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------------
//   voxel in | input     | in_valid/in_stall  | voxel_value, pos_x/y/z, last_voxel
//   crop out | output    | out_valid/out_stall| start_*, extent_*, upper_crop_*, empty
//   config   | input     | cfg_we             | cfg_idx, cfg_wdata (no read-back)
//
// One voxel transfer per cycle while in_stall is low. An ordinary voxel passes
// the input register and folds into the running box in the next cycle; only the
// voxel marked last goes on through three more registers (box, scaled size, box
// ends) to the output register, and a stall can hold it in any of them.
// Reset clears all valid bits, loads the default registers and empties the box.
// A stalled result holds in the output register while ordinary voxels keep
// flowing; in_stall rises only when a last voxel cannot move into a full tail.
`timescale 1ns / 1ps
`default_nettype none

module foreground_bounding_box_crop_core #(
	parameter int COORD_BITS = fbc_pkg::DEF_COORD_BITS,
	parameter int PIXEL_BITS = fbc_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 cfg_we,
	input  wire logic [fbc_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  wire logic [fbc_pkg::cfg_w(PIXEL_BITS, COORD_BITS)-1:0] cfg_wdata,

	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [PIXEL_BITS-1:0]                voxel_value,
	input  wire logic [COORD_BITS-1:0]                pos_x,
	input  wire logic [COORD_BITS-1:0]                pos_y,
	input  wire logic [COORD_BITS-1:0]                pos_z,
	input  wire logic                                 last_voxel,

	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic      [COORD_BITS-1:0]                start_x,
	output logic      [COORD_BITS-1:0]                start_y,
	output logic      [COORD_BITS-1:0]                start_z,
	output logic      [COORD_BITS:0]                  extent_x,
	output logic      [COORD_BITS:0]                  extent_y,
	output logic      [COORD_BITS:0]                  extent_z,
	output logic      [COORD_BITS:0]                  upper_crop_x,
	output logic      [COORD_BITS:0]                  upper_crop_y,
	output logic      [COORD_BITS:0]                  upper_crop_z,
	output logic                                      empty_flag
);
	import fbc_pkg::*;

	// Configuration
	logic [PIXEL_BITS-1:0]  bg;
	logic [MARGIN_BITS-1:0] margin;
	logic [COORD_BITS:0]    dim_x, dim_y, dim_z;

	// Stage occupancy
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic last_s1;
	logic seen_s2, seen_s3, seen_s4;
	logic empty_q;

	// Advance and free terms, from the output back to the input
	logic out_free, s4_go, s4_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;
	logic accept;
	acc_ctl_t acc_ctl;

	logic [COORD_BITS:0]   min_x_s2, min_y_s2, min_z_s2;
	logic [COORD_BITS-1:0] max_x_s2, max_y_s2, max_z_s2;

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		s4_go    = valid_s4 && out_free;
		s4_free  = !valid_s4 || out_free;
		s3_go    = valid_s3 && s4_free;
		s3_free  = !valid_s3 || s4_free;
		s2_go    = valid_s2 && s3_free;
		s2_free  = !valid_s2 || s3_free;
		// Ordinary voxels retire into the box at once; a last voxel needs room behind.
		s1_go    = valid_s1 && (!last_s1 || s2_free);
		s1_free  = !valid_s1 || s1_go;
		accept   = in_valid && s1_free;

		acc_ctl.load_s1 = accept;
		acc_ctl.step_s1 = s1_go;
		acc_ctl.load_s2 = s1_go && last_s1;
	end

	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !s1_go);
			valid_s2    <= acc_ctl.load_s2 || (valid_s2 && !s2_go);
			valid_s3    <= s2_go || (valid_s3 && !s3_go);
			valid_s4    <= s3_go || (valid_s4 && !s4_go);
			out_valid_q <= s4_go || (out_valid_q && out_stall);
		end
	end

	// Foreground-seen flag rides along with the box.
	always_ff @(posedge clk) begin
		if (s2_go) begin
			seen_s3 <= seen_s2;
		end
		if (s3_go) begin
			seen_s4 <= seen_s3;
		end
		if (s4_go) begin
			empty_q <= !seen_s4;
		end
	end

	fbc_cfg #(
		.COORD_BITS (COORD_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.bg        (bg),
		.margin    (margin),
		.dim_x     (dim_x),
		.dim_y     (dim_y),
		.dim_z     (dim_z)
	);

	fbc_accum #(
		.COORD_BITS (COORD_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (acc_ctl),
		.voxel_value (voxel_value),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.last_voxel  (last_voxel),
		.bg          (bg),
		.dim_x       (dim_x),
		.dim_y       (dim_y),
		.dim_z       (dim_z),
		.last_s1     (last_s1),
		.min_x_s2    (min_x_s2),
		.min_y_s2    (min_y_s2),
		.min_z_s2    (min_z_s2),
		.max_x_s2    (max_x_s2),
		.max_y_s2    (max_y_s2),
		.max_z_s2    (max_z_s2),
		.seen_s2     (seen_s2)
	);

	fbc_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk     (clk),
		.en_s3   (s2_go),
		.en_s4   (s3_go),
		.en_out  (s4_go),
		.fg_seen (seen_s4),
		.mn      (min_x_s2),
		.mx      (max_x_s2),
		.margin  (margin),
		.dim     (dim_x),
		.start   (start_x),
		.extent  (extent_x),
		.upper   (upper_crop_x)
	);

	fbc_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk     (clk),
		.en_s3   (s2_go),
		.en_s4   (s3_go),
		.en_out  (s4_go),
		.fg_seen (seen_s4),
		.mn      (min_y_s2),
		.mx      (max_y_s2),
		.margin  (margin),
		.dim     (dim_y),
		.start   (start_y),
		.extent  (extent_y),
		.upper   (upper_crop_y)
	);

	fbc_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
		.clk     (clk),
		.en_s3   (s2_go),
		.en_s4   (s3_go),
		.en_out  (s4_go),
		.fg_seen (seen_s4),
		.mn      (min_z_s2),
		.mx      (max_z_s2),
		.margin  (margin),
		.dim     (dim_z),
		.start   (start_z),
		.extent  (extent_z),
		.upper   (upper_crop_z)
	);

	assign out_valid  = out_valid_q;
	assign empty_flag = empty_q;

endmodule

`default_nettype wire

>>> hdl/fbc_cfg.sv
// Configuration registers of the foreground bounding-box crop core.
// Depends on fbc_pkg for register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module fbc_cfg #(
	parameter int COORD_BITS = fbc_pkg::DEF_COORD_BITS,
	parameter int PIXEL_BITS = fbc_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [fbc_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  wire logic [fbc_pkg::cfg_w(PIXEL_BITS, COORD_BITS)-1:0] cfg_wdata,
	output logic      [PIXEL_BITS-1:0]                bg,
	output logic      [fbc_pkg::MARGIN_BITS-1:0]      margin,
	output logic      [COORD_BITS:0]                  dim_x,
	output logic      [COORD_BITS:0]                  dim_y,
	output logic      [COORD_BITS:0]                  dim_z
);
	import fbc_pkg::*;

	localparam logic [COORD_BITS:0] DIM_RESET = {1'b1, {COORD_BITS{1'b0}}};

	logic [PIXEL_BITS-1:0]  bg_q;
	logic [MARGIN_BITS-1:0] margin_q;
	logic [COORD_BITS:0]    dim_x_q, dim_y_q, dim_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q     <= '0;
			margin_q <= MARGIN_RESET;
			dim_x_q  <= DIM_RESET;
			dim_y_q  <= DIM_RESET;
			dim_z_q  <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BACKGROUND: bg_q     <= cfg_wdata[PIXEL_BITS-1:0];
				CFG_MARGIN:     margin_q <= cfg_wdata[MARGIN_BITS-1:0];
				CFG_DIM_X:      dim_x_q  <= cfg_wdata[COORD_BITS:0];
				CFG_DIM_Y:      dim_y_q  <= cfg_wdata[COORD_BITS:0];
				CFG_DIM_Z:      dim_z_q  <= cfg_wdata[COORD_BITS:0];
				default: begin
				end
			endcase
		end
	end

	assign bg     = bg_q;
	assign margin = margin_q;
	assign dim_x  = dim_x_q;
	assign dim_y  = dim_y_q;
	assign dim_z  = dim_z_q;

endmodule

`default_nettype wire

>>> hdl/fbc_accum.sv
// Input register and running foreground box of the bounding-box crop core.
// Depends on fbc_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module fbc_accum #(
	parameter int COORD_BITS = fbc_pkg::DEF_COORD_BITS,
	parameter int PIXEL_BITS = fbc_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fbc_pkg::acc_ctl_t       ctl,
	input  wire logic [PIXEL_BITS-1:0]   voxel_value,
	input  wire logic [COORD_BITS-1:0]   pos_x,
	input  wire logic [COORD_BITS-1:0]   pos_y,
	input  wire logic [COORD_BITS-1:0]   pos_z,
	input  wire logic                    last_voxel,
	input  wire logic [PIXEL_BITS-1:0]   bg,
	input  wire logic [COORD_BITS:0]     dim_x,
	input  wire logic [COORD_BITS:0]     dim_y,
	input  wire logic [COORD_BITS:0]     dim_z,
	output logic                         last_s1,
	output logic [COORD_BITS:0]          min_x_s2,
	output logic [COORD_BITS:0]          min_y_s2,
	output logic [COORD_BITS:0]          min_z_s2,
	output logic [COORD_BITS-1:0]        max_x_s2,
	output logic [COORD_BITS-1:0]        max_y_s2,
	output logic [COORD_BITS-1:0]        max_z_s2,
	output logic                         seen_s2
);
	import fbc_pkg::*;

	localparam logic [COORD_BITS:0] DIM_RESET = {1'b1, {COORD_BITS{1'b0}}};

	logic [PIXEL_BITS-1:0] value_s1;
	logic [COORD_BITS-1:0] px_s1, py_s1, pz_s1;

	logic [COORD_BITS:0]   min_x_q, min_y_q, min_z_q;
	logic [COORD_BITS-1:0] max_x_q, max_y_q, max_z_q;
	logic                  seen_q;

	logic                  fg;
	logic [COORD_BITS:0]   nmin_x, nmin_y, nmin_z;
	logic [COORD_BITS-1:0] nmax_x, nmax_y, nmax_z;

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			value_s1 <= voxel_value;
			px_s1    <= pos_x;
			py_s1    <= pos_y;
			pz_s1    <= pos_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s1 <= 1'b0;
		end else if (ctl.load_s1) begin
			last_s1 <= last_voxel;
		end
	end

	// Widen the box by the voxel in the input register.
	always_comb begin
		fg     = (value_s1 != bg);
		nmin_x = (fg && ({1'b0, px_s1} < min_x_q)) ? {1'b0, px_s1} : min_x_q;
		nmin_y = (fg && ({1'b0, py_s1} < min_y_q)) ? {1'b0, py_s1} : min_y_q;
		nmin_z = (fg && ({1'b0, pz_s1} < min_z_q)) ? {1'b0, pz_s1} : min_z_q;
		nmax_x = (fg && (px_s1 > max_x_q)) ? px_s1 : max_x_q;
		nmax_y = (fg && (py_s1 > max_y_q)) ? py_s1 : max_y_q;
		nmax_z = (fg && (pz_s1 > max_z_q)) ? pz_s1 : max_z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= DIM_RESET;
			min_y_q <= DIM_RESET;
			min_z_q <= DIM_RESET;
			max_x_q <= '0;
			max_y_q <= '0;
			max_z_q <= '0;
			seen_q  <= 1'b0;
		end else if (ctl.step_s1) begin
			if (last_s1) begin
				min_x_q <= dim_x;
				min_y_q <= dim_y;
				min_z_q <= dim_z;
				max_x_q <= '0;
				max_y_q <= '0;
				max_z_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				min_x_q <= nmin_x;
				min_y_q <= nmin_y;
				min_z_q <= nmin_z;
				max_x_q <= nmax_x;
				max_y_q <= nmax_y;
				max_z_q <= nmax_z;
				seen_q  <= seen_q | fg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			min_x_s2 <= nmin_x;
			min_y_s2 <= nmin_y;
			min_z_s2 <= nmin_z;
			max_x_s2 <= nmax_x;
			max_y_s2 <= nmax_y;
			max_z_s2 <= nmax_z;
			seen_s2  <= seen_q | fg;
		end
	end

endmodule

`default_nettype wire

>>> hdl/fbc_axis.sv
// One axis of the crop result: margin scaling, centering and clipping.
// Three register levels: scaled size, box ends, output. Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc_axis #(
	parameter int COORD_BITS = fbc_pkg::DEF_COORD_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           en_s3,
	input  wire logic                           en_s4,
	input  wire logic                           en_out,
	input  wire logic                           fg_seen,
	input  wire logic [COORD_BITS:0]            mn,
	input  wire logic [COORD_BITS-1:0]          mx,
	input  wire logic [fbc_pkg::MARGIN_BITS-1:0] margin,
	input  wire logic [COORD_BITS:0]            dim,
	output logic      [COORD_BITS-1:0]          start,
	output logic      [COORD_BITS:0]            extent,
	output logic      [COORD_BITS:0]            upper
);
	import fbc_pkg::*;

	localparam int EW = COORD_BITS + 3;                       // raw extent, signed
	localparam int PW = COORD_BITS + 1 + MARGIN_BITS;         // product
	localparam int ZW = PW - MARGIN_FRAC;                     // scaled size
	localparam int SW = COORD_BITS + 12;                      // box arithmetic, signed
	localparam logic signed [EW-1:0] EXT_ONE = EW'(1);
	localparam logic signed [SW-1:0] S_ONE   = SW'(1);
	localparam logic [COORD_BITS:0]  DIM_MAX = {1'b1, {COORD_BITS{1'b0}}};
	localparam logic [COORD_BITS:0]  DIM_MIN = (COORD_BITS+1)'(1);

	logic signed [EW-1:0]   ext_raw;
	logic [COORD_BITS:0]    ext_c;
	logic [PW-1:0]          prod;

	logic [ZW-1:0]          size_s3;
	logic [COORD_BITS:0]    ext_s3;
	logic [COORD_BITS:0]    mn_s3;

	logic signed [SW-1:0]   size_w, diff, half, first_n, hi_n;
	logic signed [SW-1:0]   first_s4, hi_s4;

	logic [COORD_BITS:0]    dim_eff;
	logic signed [SW-1:0]   dim_w, lo, hic, ext_d, up_d;
	logic                   miss;

	// Inclusive extent, at least one, times the margin factor.
	always_comb begin
		ext_raw = $signed({3'b000, mx}) - $signed({2'b00, mn}) + EXT_ONE;
		ext_c   = (ext_raw < EXT_ONE) ? DIM_MIN : ext_raw[COORD_BITS:0];
		prod    = PW'(ext_c) * PW'(margin);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			size_s3 <= prod[PW-1:MARGIN_FRAC];
			ext_s3  <= ext_c;
			mn_s3   <= mn;
		end
	end

	// Center the scaled box; halve the growth toward zero.
	always_comb begin
		size_w  = $signed(SW'(size_s3));
		diff    = size_w - $signed(SW'(ext_s3));
		half    = diff[SW-1] ? ((diff + S_ONE) >>> 1) : (diff >>> 1);
		first_n = $signed(SW'(mn_s3)) - half;
		hi_n    = first_n + size_w;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			first_s4 <= first_n;
			hi_s4    <= hi_n;
		end
	end

	// Clip to [0, dim), with dim limited to the range 1 to 2**COORD_BITS.
	always_comb begin
		if (dim == '0) begin
			dim_eff = DIM_MIN;
		end else if (dim > DIM_MAX) begin
			dim_eff = DIM_MAX;
		end else begin
			dim_eff = dim;
		end
		dim_w = $signed(SW'(dim_eff));
		lo    = first_s4[SW-1] ? '0 : first_s4;
		hic   = (hi_s4 > dim_w) ? dim_w : hi_s4;
		miss  = (hic <= lo);
		ext_d = hic - lo;
		up_d  = dim_w - hic;
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			if (!fg_seen) begin
				start  <= '0;
				extent <= '0;
				upper  <= '0;
			end else if (miss) begin
				start  <= '0;
				extent <= '0;
				upper  <= dim_eff;
			end else begin
				start  <= lo[COORD_BITS-1:0];
				extent <= ext_d[COORD_BITS:0];
				upper  <= up_d[COORD_BITS:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/fbc_chk.sv
// Port-level checks for the foreground bounding-box crop core, with its bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module fbc_chk #(
	parameter int COORD_BITS = 12
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [COORD_BITS-1:0] start_x,
	input wire logic [COORD_BITS-1:0] start_y,
	input wire logic [COORD_BITS-1:0] start_z,
	input wire logic [COORD_BITS:0]   extent_x,
	input wire logic [COORD_BITS:0]   extent_y,
	input wire logic [COORD_BITS:0]   extent_z,
	input wire logic [COORD_BITS:0]   upper_crop_x,
	input wire logic [COORD_BITS:0]   upper_crop_y,
	input wire logic [COORD_BITS:0]   upper_crop_z,
	input wire logic                  empty_flag
);
	localparam logic [COORD_BITS+1:0] SPAN_MAX = (COORD_BITS+2)'(1) << COORD_BITS;

	logic [COORD_BITS+1:0] span_x, span_y, span_z;

	assign span_x = (COORD_BITS+2)'(start_x) + (COORD_BITS+2)'(extent_x)
		+ (COORD_BITS+2)'(upper_crop_x);
	assign span_y = (COORD_BITS+2)'(start_y) + (COORD_BITS+2)'(extent_y)
		+ (COORD_BITS+2)'(upper_crop_y);
	assign span_z = (COORD_BITS+2)'(start_z) + (COORD_BITS+2)'(extent_z)
		+ (COORD_BITS+2)'(upper_crop_z);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({start_x, start_y, start_z, extent_x, extent_y,
			extent_z, upper_crop_x, upper_crop_y, upper_crop_z, empty_flag}))
		else $error("stalled result changed");

	// An empty series reports an all-zero region.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_flag |-> span_x == '0 && span_y == '0 && span_z == '0)
		else $error("empty result carries a region");

	// Start, size and upper crop add up to a nonzero span no larger than the full axis range.
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_flag |-> span_x != '0 && span_x <= SPAN_MAX
			&& span_y != '0 && span_y <= SPAN_MAX && span_z != '0 && span_z <= SPAN_MAX)
		else $error("region does not fit the image bounds");

endmodule

bind foreground_bounding_box_crop_core fbc_chk #(.COORD_BITS(COORD_BITS)) u_fbc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.start_x      (start_x),
	.start_y      (start_y),
	.start_z      (start_z),
	.extent_x     (extent_x),
	.extent_y     (extent_y),
	.extent_z     (extent_z),
	.upper_crop_x (upper_crop_x),
	.upper_crop_y (upper_crop_y),
	.upper_crop_z (upper_crop_z),
	.empty_flag   (empty_flag)
);

`default_nettype wire
